[rtl/core/tmsg_pkg.sv]
// Shared constants, register map and back-end state type for the tiled
// mean / standard deviation block. No dependencies.
`default_nettype none

package tmsg_pkg;

  localparam int GRID_MAX_DEF = 64;
  localparam int MAX_DIM_DEF  = 4096;
  localparam int FRAC_BITS    = 20;
  localparam int DIV_STEPS    = 30;
  localparam int SQRT_STEPS   = 16;
  localparam int CFG_AW       = 6;
  localparam int CFG_DW       = 64;

  typedef enum logic [2:0] {
    REG_IMAGE_ROWS = 3'd0,
    REG_IMAGE_COLS = 3'd1,
    REG_GRID_ROWS  = 3'd2,
    REG_GRID_COLS  = 3'd3,
    REG_ROW_STRIDE = 3'd4,
    REG_COL_STRIDE = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_READ,
    B_MUL_QN,
    B_MUL_SS,
    B_MUL_NN,
    B_DIFF,
    B_DIV_MEAN,
    B_DIV_VAR,
    B_SQRT,
    B_OUT
  } back_state_t;

endpackage

`default_nettype wire

[rtl/core/tmsg_cmd_fifo.sv]
// Two-entry queue carrying band commands from the front end to the back end.
// Depends on nothing.
`default_nettype none

module tmsg_cmd_fifo #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty,
  output logic         full
);

  logic [W-1:0] entry [2];
  logic         wp;
  logic         rp;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign empty   = (count == 2'd0);
  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

[rtl/core/tmsg_tile_mem.sv]
// Two banks of per-tile-column accumulators (count, sum, sum of squares)
// with per-entry valid bits. Depends on tmsg_pkg.
`default_nettype none

module tmsg_tile_mem import tmsg_pkg::*; #(
  parameter  int GRID_MAX = GRID_MAX_DEF,
  parameter  int MAX_DIM  = MAX_DIM_DEF,
  localparam int IW       = $clog2(GRID_MAX),
  localparam int AW       = IW + 1,
  localparam int CW       = 2 * $clog2(MAX_DIM),
  localparam int WW       = 3 * CW + 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [WW-1:0] wdata,
  input  logic [1:0]    clr,
  input  logic [AW-1:0] raddr1,
  output logic [WW-1:0] rdata1,
  output logic          rvalid1,
  input  logic [AW-1:0] raddr2,
  output logic [WW-1:0] rdata2,
  output logic          rvalid2
);

  localparam int NB    = 1 << IW;
  localparam int DEPTH = 2 * NB;

  logic [WW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic             hit1;

  assign hit1 = we && (waddr == raddr1);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata1 <= hit1 ? wdata : mem[raddr1];
    rdata2 <= mem[raddr2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      rvalid1 <= 1'b0;
      rvalid2 <= 1'b0;
    end else begin
      for (int b = 0; b < 2; b++) begin
        if (clr[b]) begin
          valid[b*NB +: NB] <= '0;
        end
      end
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rvalid1 <= hit1 || (valid[raddr1] && !clr[raddr1[AW-1]]);
      rvalid2 <= valid[raddr2];
    end
  end

endmodule

`default_nettype wire

[rtl/core/tmsg_front.sv]
// Pixel front end: raster position, tile and band boundaries, accumulation
// into the tile memory and band command issue. Depends on tmsg_pkg.
`default_nettype none

module tmsg_front import tmsg_pkg::*; #(
  parameter  int GRID_MAX = GRID_MAX_DEF,
  parameter  int MAX_DIM  = MAX_DIM_DEF,
  localparam int IW       = $clog2(GRID_MAX),
  localparam int GW       = IW + 1,
  localparam int AW       = IW + 1,
  localparam int LOG      = $clog2(MAX_DIM),
  localparam int CW       = 2 * LOG,
  localparam int SUMW     = CW + 8,
  localparam int SQW      = CW + 16,
  localparam int WW       = CW + SUMW + SQW,
  localparam int CMDW     = 2 * GW + 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [12:0]     image_rows,
  input  logic [12:0]     image_cols,
  input  logic [6:0]      grid_rows,
  input  logic [6:0]      grid_cols,
  input  logic [32:0]     row_stride,
  input  logic [32:0]     col_stride,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      pixel,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output logic [WW-1:0]   mem_wdata,
  output logic [1:0]      mem_clr,
  output logic [AW-1:0]   mem_raddr,
  input  logic [WW-1:0]   mem_rdata,
  input  logic            mem_rvalid,
  output logic            cmd_push,
  output logic [CMDW-1:0] cmd_data,
  input  logic            band_done,
  input  logic            done_bank,
  output logic [1:0]      busy
);

  localparam int PW = LOG;
  localparam int DW = LOG + 1;
  localparam int BW = (LOG + 21 > 33) ? LOG + 21 : 33;
  localparam logic [BW-1:0] ONE_Q = BW'(1) << FRAC_BITS;
  localparam logic [BW-1:0] CAP_Q = BW'(MAX_DIM) << FRAC_BITS;

  function automatic logic [BW-1:0] advance(input logic [BW-1:0] b,
                                            input logic [BW-1:0] s);
    logic [BW:0] n;
    n = {1'b0, b} + {1'b0, s};
    return (n > {1'b0, CAP_Q}) ? CAP_Q : n[BW-1:0];
  endfunction

  logic [PW-1:0] r;
  logic [PW-1:0] c;
  logic [GW-1:0] band;
  logic [GW-1:0] tci;
  logic [BW-1:0] nrb;
  logic [BW-1:0] ncb;
  logic          bank;
  logic [1:0]    busy_next;

  logic [DW-1:0] rows_e, cols_e;
  logic [GW-1:0] gr, gc;
  logic [BW-1:0] rs_e, cs_e;
  logic          first;
  logic [GW-1:0] band_e, j_e, tci_n, j_next;
  logic [BW-1:0] nrb_e, ncb_e, c_lim, r_lim;
  logic          acc, adv, row_end, close, final_band, take, bank_n;
  logic [WW-1:0] base;
  logic [CW-1:0] base_cnt;
  logic [SUMW-1:0] base_sum;
  logic [SQW-1:0]  base_sq;

  always_comb begin
    if (image_rows < 13'd2) begin
      rows_e = DW'(2);
    end else if (32'(image_rows) > 32'(MAX_DIM)) begin
      rows_e = DW'(MAX_DIM);
    end else begin
      rows_e = DW'(image_rows);
    end
    if (image_cols < 13'd2) begin
      cols_e = DW'(2);
    end else if (32'(image_cols) > 32'(MAX_DIM)) begin
      cols_e = DW'(MAX_DIM);
    end else begin
      cols_e = DW'(image_cols);
    end
    if (grid_rows == 7'd0) begin
      gr = GW'(1);
    end else if (32'(grid_rows) > 32'(GRID_MAX)) begin
      gr = GW'(GRID_MAX);
    end else begin
      gr = GW'(grid_rows);
    end
    if (grid_cols == 7'd0) begin
      gc = GW'(1);
    end else if (32'(grid_cols) > 32'(GRID_MAX)) begin
      gc = GW'(GRID_MAX);
    end else begin
      gc = GW'(grid_cols);
    end
    rs_e = (row_stride < 33'(ONE_Q)) ? ONE_Q : BW'(row_stride);
    cs_e = (col_stride < 33'(ONE_Q)) ? ONE_Q : BW'(col_stride);
  end

  always_comb begin
    first   = (r == '0) && (c == '0);
    band_e  = first ? '0 : band;
    nrb_e   = first ? rs_e : nrb;
    j_e     = (c == '0) ? '0 : tci;
    ncb_e   = (c == '0) ? cs_e : ncb;
    c_lim   = BW'(DW'(c) + DW'(2)) << FRAC_BITS;
    r_lim   = BW'(DW'(r) + DW'(2)) << FRAC_BITS;
    acc     = (DW'(r) < rows_e - DW'(1)) && (DW'(c) < cols_e - DW'(1)) &&
              (band_e < gr) && (j_e < gc);
    adv     = (ncb_e < c_lim) && (j_e < gc);
    row_end = (DW'(c) >= cols_e - DW'(1));
    close   = row_end && (band_e < gr) &&
              ((DW'(r) + DW'(2) >= rows_e) || (nrb_e < r_lim));
    final_band = (band_e == gr - GW'(1)) || (DW'(r) >= rows_e - DW'(1));
    in_ready = !(close && busy[~bank]);
    take     = in_valid && in_ready;
    tci_n    = adv ? j_e + GW'(1) : j_e;
    j_next   = row_end ? '0 : tci_n;
    bank_n   = close ? ~bank : bank;
  end

  always_comb begin
    base = (mem_rvalid && !first) ? mem_rdata : '0;
    {base_sq, base_sum, base_cnt} = base;
    mem_we    = take && acc;
    mem_waddr = {bank, j_e[IW-1:0]};
    mem_wdata = {base_sq + SQW'(16'(pixel) * 16'(pixel)),
                 base_sum + SUMW'(pixel),
                 base_cnt + CW'(1)};
    mem_raddr = take ? {bank_n, j_next[IW-1:0]} : {bank, j_e[IW-1:0]};
    mem_clr   = '0;
    if (take && first) begin
      mem_clr[bank] = 1'b1;
    end
    if (take && close) begin
      mem_clr[~bank] = 1'b1;
    end
    cmd_push  = take && close;
    cmd_data  = {final_band, bank, gc, band_e};
    busy_next = busy;
    if (band_done) begin
      busy_next[done_bank] = 1'b0;
    end
    if (cmd_push) begin
      busy_next[bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r    <= '0;
      c    <= '0;
      band <= '0;
      tci  <= '0;
      nrb  <= ONE_Q;
      ncb  <= ONE_Q;
      bank <= 1'b0;
      busy <= '0;
    end else begin
      busy <= busy_next;
      if (take) begin
        c    <= row_end ? '0 : c + PW'(1);
        if (row_end) begin
          r <= (DW'(r) >= rows_e - DW'(1)) ? '0 : r + PW'(1);
        end
        band <= close ? band_e + GW'(1) : band_e;
        nrb  <= close ? advance(nrb_e, rs_e) : nrb_e;
        tci  <= tci_n;
        ncb  <= adv ? advance(ncb_e, cs_e) : ncb_e;
        bank <= bank_n;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/tmsg_back.sv]
// Statistics back end: per tile of a closed band, mean and standard deviation
// by multiplies, restoring divide and digit square root. Depends on tmsg_pkg.
`default_nettype none

module tmsg_back import tmsg_pkg::*; #(
  parameter  int GRID_MAX = GRID_MAX_DEF,
  parameter  int MAX_DIM  = MAX_DIM_DEF,
  localparam int IW       = $clog2(GRID_MAX),
  localparam int GW       = IW + 1,
  localparam int AW       = IW + 1,
  localparam int CW       = 2 * $clog2(MAX_DIM),
  localparam int SUMW     = CW + 8,
  localparam int SQW      = CW + 16,
  localparam int WW       = CW + SUMW + SQW,
  localparam int CMDW     = 2 * GW + 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  logic [CMDW-1:0] cmd_data,
  output logic            cmd_pop,
  output logic [AW-1:0]   mem_raddr,
  input  logic [WW-1:0]   mem_rdata,
  input  logic            mem_rvalid,
  output logic            band_done,
  output logic            done_bank,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [5:0]      tile_row,
  output logic [5:0]      tile_col,
  output logic [15:0]     mean,
  output logic [15:0]     stddev,
  output logic            last
);

  localparam int PDW = 2 * CW + 16;
  localparam int NNW = 2 * CW;
  localparam int NW  = 2 * CW + 32;

  back_state_t state, state_next;

  logic [GW-1:0]   band, gc, j;
  logic            bank, fin;
  logic [SUMW-1:0] s_r;
  logic [CW-1:0]   n_r;
  logic [PDW-1:0]  prod_qn, prod_ss, d;
  logic [NNW-1:0]  den;
  logic [NNW-1:0]  rem;
  logic [DIV_STEPS-1:0] low, quo;
  logic [4:0]      step;
  logic [31:0]     sv, res, sbit;
  logic [15:0]     mean_r, sd_r;

  logic [CW-1:0]   rd_cnt;
  logic [SUMW-1:0] rd_sum;
  logic [SQW-1:0]  rd_sq;
  logic [NNW:0]    t;
  logic            ge;
  logic [NW-1:0]   numm, numv;
  logic            out_free, tile_last;

  assign {rd_sq, rd_sum, rd_cnt} = mem_rdata;
  assign mem_raddr = {bank, j[IW-1:0]};
  assign t         = {rem, low[DIV_STEPS-1]};
  assign ge        = (t >= {1'b0, den});
  assign numm      = NW'({s_r, 8'h00});
  assign numv      = {d, 16'h0000};
  assign out_free  = !out_valid || out_ready;
  assign tile_last = (j == gc - GW'(1));
  assign done_bank = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    band_done  = 1'b0;
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          state_next = B_READ;
        end
      end
      B_READ:   state_next = B_MUL_QN;
      B_MUL_QN: state_next = (!mem_rvalid || rd_cnt == '0) ? B_OUT : B_MUL_SS;
      B_MUL_SS: state_next = B_MUL_NN;
      B_MUL_NN: state_next = B_DIFF;
      B_DIFF:   state_next = B_DIV_MEAN;
      B_DIV_MEAN: begin
        if (step == 5'(DIV_STEPS)) begin
          state_next = B_DIV_VAR;
        end
      end
      B_DIV_VAR: begin
        if (step == 5'(DIV_STEPS)) begin
          state_next = B_SQRT;
        end
      end
      B_SQRT: begin
        if (step == 5'(SQRT_STEPS)) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (out_free) begin
          if (tile_last) begin
            band_done  = 1'b1;
            state_next = B_IDLE;
          end else begin
            state_next = B_READ;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          band <= cmd_data[GW-1:0];
          gc   <= cmd_data[2*GW-1:GW];
          bank <= cmd_data[2*GW];
          fin  <= cmd_data[2*GW+1];
          j    <= '0;
        end
      end
      B_MUL_QN: begin
        prod_qn <= rd_sq * rd_cnt;
        s_r     <= rd_sum;
        n_r     <= rd_cnt;
        mean_r  <= '0;
        sd_r    <= '0;
      end
      B_MUL_SS: prod_ss <= s_r * s_r;
      B_MUL_NN: den <= n_r * n_r;
      B_DIFF: begin
        d    <= (prod_qn >= prod_ss) ? prod_qn - prod_ss : '0;
        rem  <= NNW'(numm >> DIV_STEPS);
        low  <= numm[DIV_STEPS-1:0];
        quo  <= '0;
        step <= '0;
        den  <= NNW'(n_r);
        prod_ss <= den[NNW-1:0] == '0 ? prod_ss : prod_ss;
      end
      B_DIV_MEAN, B_DIV_VAR: begin
        if (step == 5'(DIV_STEPS)) begin
          step <= '0;
          quo  <= '0;
          if (state == B_DIV_MEAN) begin
            mean_r <= quo[15:0];
            rem    <= NNW'(numv >> DIV_STEPS);
            low    <= numv[DIV_STEPS-1:0];
            den    <= n_r * n_r;
          end else begin
            sv   <= 32'(quo);
            res  <= '0;
            sbit <= 32'd1 << 30;
          end
        end else begin
          rem  <= ge ? NNW'(t - {1'b0, den}) : t[NNW-1:0];
          quo  <= {quo[DIV_STEPS-2:0], ge};
          low  <= low << 1;
          step <= step + 5'd1;
        end
      end
      B_SQRT: begin
        if (step == 5'(SQRT_STEPS)) begin
          sd_r <= res[15:0];
        end else begin
          if (sv >= res + sbit) begin
            sv  <= sv - (res + sbit);
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
          sbit <= sbit >> 2;
          step <= step + 5'd1;
        end
      end
      B_OUT: begin
        if (out_free && !tile_last) begin
          j <= j + GW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && out_free) begin
      tile_row <= 6'(band);
      tile_col <= 6'(j);
      mean     <= mean_r;
      stddev   <= sd_r;
      last     <= fin && tile_last;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tile_mean_stddev_grid.sv]
// Top level of the tiled mean / standard deviation block: register port,
// front end, band queue, tile memory and back end. Depends on tmsg_pkg.
//
// Pixels enter on in_valid/in_ready, one per cycle, in raster order; each
// frame restarts after its last pixel. Every pixel that does not close a band
// is taken at once. The pixel that closes a band is held off only while the
// back end is still emitting the previous band, as the tile memory has two
// banks: one filled by the front end, one read by the back end.
// Results leave on out_valid/out_ready, one transaction per tile, band by band,
// tile column 0 first. A non-empty tile passes through the back end in order:
// read, three multiply states, a set-up state, two 30-step restoring
// divisions, a 16-step square root and output; an empty tile goes from the
// first multiply state straight to output.
// When the receiver stalls, the output register holds the tile and the back
// end waits; pixel intake carries on until the next band close.
// Reset clears position, bounds, queue and valid bits; registers return to
// their reset values. No clearing pass is needed.
// Registers sit at byte addresses 8*i on the APB-style port.
`default_nettype none

module tile_mean_stddev_grid import tmsg_pkg::*; #(
  parameter int GRID_MAX = GRID_MAX_DEF,
  parameter int MAX_DIM  = MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        tile_row,
  output logic [5:0]        tile_col,
  output logic [15:0]       mean,
  output logic [15:0]       stddev,
  output logic              last
);

  localparam int IW   = $clog2(GRID_MAX);
  localparam int GW   = IW + 1;
  localparam int AW   = IW + 1;
  localparam int CW   = 2 * $clog2(MAX_DIM);
  localparam int WW   = 3 * CW + 24;
  localparam int CMDW = 2 * GW + 2;

  logic [12:0] image_rows, image_cols;
  logic [6:0]  grid_rows, grid_cols;
  logic [32:0] row_stride, col_stride;
  cfg_reg_t    reg_sel;

  logic            mem_we, mem_rvalid1, mem_rvalid2;
  logic [AW-1:0]   mem_waddr, mem_raddr1, mem_raddr2;
  logic [WW-1:0]   mem_wdata, mem_rdata1, mem_rdata2;
  logic [1:0]      mem_clr, busy;
  logic            cmd_push, cmd_pop, fifo_empty, fifo_full;
  logic [CMDW-1:0] cmd_in, cmd_out;
  logic            band_done, done_bank;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= 13'd64;
      image_cols <= 13'd64;
      grid_rows  <= 7'd64;
      grid_cols  <= 7'd64;
      row_stride <= 33'd1 << FRAC_BITS;
      col_stride <= 33'd1 << FRAC_BITS;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_IMAGE_ROWS: image_rows <= pwdata[12:0];
        REG_IMAGE_COLS: image_cols <= pwdata[12:0];
        REG_GRID_ROWS:  grid_rows  <= pwdata[6:0];
        REG_GRID_COLS:  grid_cols  <= pwdata[6:0];
        REG_ROW_STRIDE: row_stride <= pwdata[32:0];
        REG_COL_STRIDE: col_stride <= pwdata[32:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IMAGE_ROWS: prdata = CFG_DW'(image_rows);
      REG_IMAGE_COLS: prdata = CFG_DW'(image_cols);
      REG_GRID_ROWS:  prdata = CFG_DW'(grid_rows);
      REG_GRID_COLS:  prdata = CFG_DW'(grid_cols);
      REG_ROW_STRIDE: prdata = CFG_DW'(row_stride);
      REG_COL_STRIDE: prdata = CFG_DW'(col_stride);
      default:        prdata = '0;
    endcase
  end

  tmsg_front #(.GRID_MAX(GRID_MAX), .MAX_DIM(MAX_DIM)) u_front (
    .clk        (clk),
    .rst        (rst),
    .image_rows (image_rows),
    .image_cols (image_cols),
    .grid_rows  (grid_rows),
    .grid_cols  (grid_cols),
    .row_stride (row_stride),
    .col_stride (col_stride),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel      (pixel),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_clr    (mem_clr),
    .mem_raddr  (mem_raddr1),
    .mem_rdata  (mem_rdata1),
    .mem_rvalid (mem_rvalid1),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_in),
    .band_done  (band_done),
    .done_bank  (done_bank),
    .busy       (busy)
  );

  tmsg_cmd_fifo #(.W(CMDW)) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (fifo_empty),
    .full  (fifo_full)
  );

  tmsg_tile_mem #(.GRID_MAX(GRID_MAX), .MAX_DIM(MAX_DIM)) u_tile_mem (
    .clk     (clk),
    .rst     (rst),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .clr     (mem_clr),
    .raddr1  (mem_raddr1),
    .rdata1  (mem_rdata1),
    .rvalid1 (mem_rvalid1),
    .raddr2  (mem_raddr2),
    .rdata2  (mem_rdata2),
    .rvalid2 (mem_rvalid2)
  );

  tmsg_back #(.GRID_MAX(GRID_MAX), .MAX_DIM(MAX_DIM)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (!fifo_empty),
    .cmd_data   (cmd_out),
    .cmd_pop    (cmd_pop),
    .mem_raddr  (mem_raddr2),
    .mem_rdata  (mem_rdata2),
    .mem_rvalid (mem_rvalid2),
    .band_done  (band_done),
    .done_bank  (done_bank),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tile_row   (tile_row),
    .tile_col   (tile_col),
    .mean       (mean),
    .stddev     (stddev),
    .last       (last)
  );

  a_one_bank_busy: assert property (@(posedge clk) disable iff (rst)
    !(busy[0] && busy[1]))
    else $error("both tile banks owned by the back end");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !fifo_full)
    else $error("band command pushed into a full queue");

  a_done_owned: assert property (@(posedge clk) disable iff (rst)
    band_done |-> busy[done_bank])
    else $error("band finished on a bank that was not handed over");

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for tile_mean_stddev_grid: drives pixel frames under
// several register settings, predicts per-tile mean/stddev, checks results.
// Depends on tmsg_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;
  import tmsg_pkg::*;

  typedef struct packed {
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] mean;
    logic [15:0] sd;
    logic        last;
  } tile_stat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0, in_ready;
  logic [7:0]        pixel = '0;
  logic              out_valid, out_ready = 1'b0;
  logic [5:0]        tile_row, tile_col;
  logic [15:0]       mean, stddev;
  logic              last;

  tile_mean_stddev_grid dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // ---- predictor state ----
  longint unsigned cfg_rows, cfg_cols, cfg_grows, cfg_gcols, cfg_rstride, cfg_cstride;
  longint unsigned acc_sum[64], acc_sq[64], acc_cnt[64];
  longint unsigned pos_row, pos_col, band, tcol, row_bound, col_bound;

  tile_stat_t      tile_q[$];
  logic [7:0]      pixel_q[$];
  int              errors = 0;
  bit              calm = 0;
  int              hold_req = 0;
  int              hold_cnt = 0;

  function automatic longint unsigned clampv(longint unsigned v, longint unsigned lo,
                                             longint unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res = 0, b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned bump(longint unsigned b, longint unsigned s);
    longint unsigned n = b + s;
    return n > (64'd4096 << 20) ? (64'd4096 << 20) : n;
  endfunction

  function automatic void clear_acc();
    for (int j = 0; j < 64; j++) begin
      acc_sum[j] = 0;
      acc_sq[j] = 0;
      acc_cnt[j] = 0;
    end
  endfunction

  function automatic void reset_model();
    cfg_rows = 64; cfg_cols = 64; cfg_grows = 64; cfg_gcols = 64;
    cfg_rstride = 1 << 20; cfg_cstride = 1 << 20;
    clear_acc();
    pos_row = 0; pos_col = 0; band = 0; tcol = 0;
    row_bound = 1 << 20; col_bound = 1 << 20;
  endfunction

  function automatic void accept_pixel(logic [7:0] px);
    longint unsigned nr, nc, gr, gc, rs, cs, p, r, c, n, s, q, d, q1, r1, x;
    tile_stat_t t;
    bit fin;
    nr = clampv(cfg_rows, 2, 4096);
    nc = clampv(cfg_cols, 2, 4096);
    gr = clampv(cfg_grows, 1, 64);
    gc = clampv(cfg_gcols, 1, 64);
    rs = cfg_rstride < (1 << 20) ? (1 << 20) : cfg_rstride;
    cs = cfg_cstride < (1 << 20) ? (1 << 20) : cfg_cstride;
    p = px; r = pos_row; c = pos_col;
    if (r == 0 && c == 0) begin
      band = 0;
      row_bound = rs;
      clear_acc();
    end
    if (c == 0) begin
      tcol = 0;
      col_bound = cs;
    end
    if (r < nr - 1 && c < nc - 1 && band < gr && tcol < gc) begin
      acc_sum[tcol] += p;
      acc_sq[tcol] += p * p;
      acc_cnt[tcol] += 1;
    end
    if (col_bound < ((c + 2) << 20) && tcol < gc) begin
      tcol++;
      col_bound = bump(col_bound, cs);
    end
    if (c >= nc - 1) begin
      if (band < gr && (r + 2 >= nr || row_bound < ((r + 2) << 20))) begin
        fin = (band == gr - 1) || (r >= nr - 1);
        for (int j = 0; j < gc; j++) begin
          n = acc_cnt[j]; s = acc_sum[j]; q = acc_sq[j];
          t.row = band[5:0];
          t.col = j[5:0];
          t.last = fin && (j == gc - 1);
          if (n == 0) begin
            t.mean = 0;
            t.sd = 0;
          end else begin
            t.mean = 16'((s << 8) / n);
            d = q * n;
            d = d >= s * s ? d - s * s : 0;
            q1 = d / n;
            r1 = d % n;
            x = (q1 << 16) + ((r1 << 16) / n);
            t.sd = 16'(root64(x / n));
          end
          tile_q.push_back(t);
        end
        clear_acc();
        band++;
        row_bound = bump(row_bound, rs);
      end
      pos_col = 0;
      pos_row = (r >= nr - 1) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
  endfunction

  // ---- pixel driver ----
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) accept_pixel(pixel);
      if (!in_valid || in_ready) begin
        if (pixel_q.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
          in_valid <= 1'b1;
          pixel <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- result monitor ----
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (tile_q.size() == 0) begin
          $error("unexpected tile row %0d col %0d", tile_row, tile_col);
          errors++;
        end else begin
          tile_stat_t e;
          e = tile_q.pop_front();
          if (tile_row !== e.row) begin
            $error("tile_row exp %0d got %0d", e.row, tile_row); errors++;
          end
          if (tile_col !== e.col) begin
            $error("tile_col exp %0d got %0d", e.col, tile_col); errors++;
          end
          if (mean !== e.mean) begin
            $error("mean exp %0h got %0h", e.mean, mean); errors++;
          end
          if (stddev !== e.sd) begin
            $error("stddev exp %0h got %0h", e.sd, stddev); errors++;
          end
          if (last !== e.last) begin
            $error("last exp %0b got %0b", e.last, last); errors++;
          end
        end
      end
      if (hold_req > 0 && hold_cnt == 0) begin
        hold_cnt <= hold_req;
        out_ready <= 1'b0;
      end else if (hold_cnt > 1) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        hold_cnt <= 0;
        out_ready <= calm || $urandom_range(99) >= 19;
      end
    end
  end

  task automatic reg_write(cfg_reg_t idx, longint unsigned val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'(idx * 8); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_IMAGE_ROWS: cfg_rows = val & 64'h1FFF;
      REG_IMAGE_COLS: cfg_cols = val & 64'h1FFF;
      REG_GRID_ROWS:  cfg_grows = val & 64'h7F;
      REG_GRID_COLS:  cfg_gcols = val & 64'h7F;
      REG_ROW_STRIDE: cfg_rstride = val & 64'h1_FFFF_FFFF;
      REG_COL_STRIDE: cfg_cstride = val & 64'h1_FFFF_FFFF;
      default: ;
    endcase
  endtask

  task automatic setup(longint unsigned r, longint unsigned c, longint unsigned gr,
                       longint unsigned gc, longint unsigned rs, longint unsigned cs);
    reg_write(REG_IMAGE_ROWS, r);
    reg_write(REG_IMAGE_COLS, c);
    reg_write(REG_GRID_ROWS, gr);
    reg_write(REG_GRID_COLS, gc);
    reg_write(REG_ROW_STRIDE, rs);
    reg_write(REG_COL_STRIDE, cs);
  endtask

  task automatic drain();
    wait (pixel_q.size() == 0 && !in_valid && tile_q.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  function automatic int frame_len();
    return int'(clampv(cfg_rows, 2, 4096) * clampv(cfg_cols, 2, 4096));
  endfunction

  task automatic random_frames(int frames);
    for (int f = 0; f < frames; f++)
      for (int i = 0; i < frame_len(); i++) pixel_q.push_back(8'($urandom));
  endtask

  initial begin
    int sent;
    int n;
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes of pixel values
    setup(4, 5, 2, 2, 64'd1572864, 64'd1572864);
    for (int i = 0; i < 20; i++)
      pixel_q.push_back(i < 5 ? 8'd0 : (i < 10 ? 8'd255 : (i[0] ? 8'hAA : 8'h55)));
    for (int i = 0; i < 20; i++) pixel_q.push_back(i[0] ? 8'hFF : 8'h00);
    drain();
    // grid larger than image
    setup(3, 3, 4, 4, 1 << 20, 1 << 20);
    random_frames(2);
    drain();
    // grid smaller than image
    setup(6, 6, 2, 2, 1 << 20, 1 << 20);
    random_frames(1);
    drain();
    // stride below one, full grid width, long receiver stall
    setup(6, 4, 3, 64, 0, 64'd524288);
    hold_req = 3000;
    random_frames(2);
    wait (hold_cnt > 0);
    hold_req = 0;
    drain();
    // clamped sizes and largest strides
    setup(0, 40, 0, 127, 64'h1_FFFF_FFFF, 64'h1_FFFF_FFFF);
    calm = 1;
    random_frames(1);
    drain();
    setup(30, 0, 127, 127, 1 << 20, 1 << 20);
    random_frames(1);
    drain();
    calm = 0;

    sent = 0;
    while (sent < 60) begin
      setup($urandom_range(2, 10), $urandom_range(2, 10), $urandom_range(1, 8),
            $urandom_range(1, 8), $urandom_range(524288, 4194304),
            $urandom_range(524288, 4194304));
      calm = ($urandom_range(5) == 0);
      n = $urandom_range(1, 3);
      random_frames(n);
      sent += n * frame_len();
      drain();
    end
    calm = 0;
    drain();

    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #40ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
